/* hw/rtl/spcs_pkg.sv */
// Shared types and constants for the shifted parity correlation sums block.
// No dependencies; used by the core and by its checker.
package spcs_pkg;

   localparam int WINDOW_BITS   = 64;   // bits kept in the parity window
   localparam int SUM_WIDTH     = 41;   // accumulator width, saturating
   localparam int OUT_SUM_WIDTH = 41;
   localparam int COUNT_WIDTH   = 40;
   localparam int SHIFT_K_WIDTH = 5;
   localparam int SHIFT_H_WIDTH = 6;
   localparam int SPAN_WIDTH    = 7;    // k + h
   localparam int WIN_IDX_WIDTH = $clog2(WINDOW_BITS);
   localparam int SEEN_WIDTH    = $clog2(WINDOW_BITS + 1);
   localparam int CMP_WIDTH     = 9;    // holds span, bits seen and the window size
   localparam int CSR_IDX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 8;

   typedef logic signed [SUM_WIDTH-1:0]     acc_type;
   typedef logic signed [OUT_SUM_WIDTH-1:0] sum_out_type;
   typedef logic [COUNT_WIDTH-1:0]          count_type;
   typedef logic [SHIFT_K_WIDTH-1:0]        shift_k_type;
   typedef logic [SHIFT_H_WIDTH-1:0]        shift_h_type;
   typedef logic [CSR_IDX_WIDTH-1:0]        csr_idx_type;
   typedef logic [CSR_DATA_WIDTH-1:0]       csr_data_type;

   localparam csr_idx_type REG_SHIFT_K = csr_idx_type'(0);
   localparam csr_idx_type REG_SHIFT_H = csr_idx_type'(1);

   localparam shift_k_type RESET_SHIFT_K = shift_k_type'(11);
   localparam shift_h_type RESET_SHIFT_H = shift_h_type'(6);

   // symmetric saturation bounds +/-(2^(SUM_WIDTH-1) - 1)
   localparam acc_type SUM_MAX = acc_type'({1'b0, {(SUM_WIDTH-1){1'b1}}});
   localparam acc_type SUM_MIN = acc_type'({1'b1, {(SUM_WIDTH-2){1'b0}}, 1'b1});
   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [CMP_WIDTH-1:0] WIN_LIMIT = CMP_WIDTH'(WINDOW_BITS);

endpackage

/* hw/rtl/shifted_parity_correlation_sums_core.sv */
// Top level of the shifted parity correlation sums block.
// Depends on spcs_pkg for widths, register indexes and saturation bounds.

// One parity bit per beat, accepted every cycle unless the input register
// holds. A beat lands in an input register and is then folded into the bit
// window, and into the three saturating sums and the term count when a term
// is complete; a beat with report set also loads the result register, from
// the sums that include it. The input register keeps taking beats while a
// result waits, and holds only when it carries a report and the result
// register is still occupied and not being read. Shift writes are taken at
// any time and should be made while the block is idle.
module shifted_parity_correlation_sums_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_parity_bit,
   input  logic                        req_report,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output spcs_pkg::sum_out_type       rsp_sum_four,
   output spcs_pkg::sum_out_type       rsp_sum_first_pair,
   output spcs_pkg::sum_out_type       rsp_sum_second_pair,
   output spcs_pkg::count_type         rsp_terms_done,
   output logic                        rsp_overflowed,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  spcs_pkg::csr_idx_type       csr_index,
   input  spcs_pkg::csr_data_type      csr_wdata
);
   import spcs_pkg::*;

   typedef struct packed {
      acc_type acc;
      logic    hit;
   } sat_res_type;

   // down = 1 steps by -1
   function automatic sat_res_type sat_step(acc_type acc, logic down);
      sat_res_type r;
      r.acc = acc;
      r.hit = 1'b0;
      if (down) begin
         if (acc <= SUM_MIN) r.hit = 1'b1;
         else                r.acc = acc - acc_type'(1);
      end else begin
         if (acc >= SUM_MAX) r.hit = 1'b1;
         else                r.acc = acc + acc_type'(1);
      end
      return r;
   endfunction

   shift_k_type shift_k_ff;
   shift_h_type shift_h_ff;

   logic in_valid_ff, in_bit_ff, in_report_ff;
   logic advance;

   logic [WINDOW_BITS-1:0] win_ff, win_in;
   logic [SEEN_WIDTH-1:0]  seen_ff, seen_in;
   acc_type   acc_four_ff, acc_first_ff, acc_second_ff;
   count_type count_ff, count_in;
   logic      sat_ff, sat_in;

   logic [SPAN_WIDTH-1:0] span;
   logic                  term_en;
   logic                  a_bit, b_bit;
   sat_res_type           step_four, step_first, step_second;
   acc_type               acc_four_in, acc_first_in, acc_second_in;

   logic        rsp_valid_ff;
   sum_out_type rsp_four_ff, rsp_first_ff, rsp_second_ff;
   count_type   rsp_terms_ff;
   logic        rsp_ovf_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_k_ff <= RESET_SHIFT_K;
         shift_h_ff <= RESET_SHIFT_H;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SHIFT_K: shift_k_ff <= csr_wdata[SHIFT_K_WIDTH-1:0];
            REG_SHIFT_H: shift_h_ff <= csr_wdata[SHIFT_H_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input stage stalls only on a report beat that has nowhere to go
   assign advance   = in_valid_ff && (!in_report_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_bit_ff    <= req_parity_bit;
         in_report_ff <= req_report;
      end
   end

   // newest bit sits at index 0, so win[i] is the bit i beats back
   always_comb begin
      win_in  = {win_ff[WINDOW_BITS-2:0], in_bit_ff};
      seen_in = seen_ff;
      if (CMP_WIDTH'(seen_ff) < WIN_LIMIT) seen_in = seen_ff + SEEN_WIDTH'(1);
      span    = SPAN_WIDTH'(shift_k_ff) + SPAN_WIDTH'(shift_h_ff);
      term_en = (CMP_WIDTH'(span) < WIN_LIMIT) && (CMP_WIDTH'(seen_in) > CMP_WIDTH'(span));
      a_bit   = win_in[span[WIN_IDX_WIDTH-1:0]]
                ^ win_in[WIN_IDX_WIDTH'(shift_h_ff)];
      b_bit   = win_in[WIN_IDX_WIDTH'(shift_k_ff)] ^ win_in[0];
      step_four   = sat_step(acc_four_ff, a_bit ^ b_bit);
      step_first  = sat_step(acc_first_ff, a_bit);
      step_second = sat_step(acc_second_ff, b_bit);

      acc_four_in   = acc_four_ff;
      acc_first_in  = acc_first_ff;
      acc_second_in = acc_second_ff;
      count_in      = count_ff;
      sat_in        = sat_ff;
      if (term_en) begin
         acc_four_in   = step_four.acc;
         acc_first_in  = step_first.acc;
         acc_second_in = step_second.acc;
         if (count_ff == COUNT_MAX) sat_in = 1'b1;
         else                       count_in = count_ff + count_type'(1);
         if (step_four.hit || step_first.hit || step_second.hit) sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff        <= '0;
         seen_ff       <= '0;
         acc_four_ff   <= '0;
         acc_first_ff  <= '0;
         acc_second_ff <= '0;
         count_ff      <= '0;
         sat_ff        <= 1'b0;
      end else if (advance) begin
         win_ff        <= win_in;
         seen_ff       <= seen_in;
         acc_four_ff   <= acc_four_in;
         acc_first_ff  <= acc_first_in;
         acc_second_ff <= acc_second_in;
         count_ff      <= count_in;
         sat_ff        <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_report_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_report_ff) begin
         rsp_four_ff   <= sum_out_type'(acc_four_in);
         rsp_first_ff  <= sum_out_type'(acc_first_in);
         rsp_second_ff <= sum_out_type'(acc_second_in);
         rsp_terms_ff  <= count_in;
         rsp_ovf_ff    <= sat_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sum_four        = rsp_four_ff;
   assign rsp_sum_first_pair  = rsp_first_ff;
   assign rsp_sum_second_pair = rsp_second_ff;
   assign rsp_terms_done      = rsp_terms_ff;
   assign rsp_overflowed      = rsp_ovf_ff;

endmodule

/* hw/rtl/spcs_checker.sv */
// Port-level checks for shifted_parity_correlation_sums_core, bound to it below.
// Depends on spcs_pkg for the result field types.
module spcs_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input spcs_pkg::sum_out_type rsp_sum_four,
   input spcs_pkg::sum_out_type rsp_sum_first_pair,
   input spcs_pkg::sum_out_type rsp_sum_second_pair,
   input spcs_pkg::count_type   rsp_terms_done,
   input logic                  rsp_overflowed
);
   import spcs_pkg::*;

   // no result straight out of reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // a stalled result beat stays valid with its count, four-point sum and flag stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_terms_done)
         && $stable(rsp_sum_four) && $stable(rsp_overflowed))
      else $error("stalled result beat changed");

   // every term moves each sum by one, so parities track the count until saturation
   a_first_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflowed |-> rsp_sum_first_pair[0] == rsp_terms_done[0])
      else $error("first pair sum parity disagrees with term count");

   a_second_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflowed |-> rsp_sum_second_pair[0] == rsp_terms_done[0])
      else $error("second pair sum parity disagrees with term count");

   a_four_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflowed |-> rsp_sum_four[0] == rsp_terms_done[0])
      else $error("four-point sum parity disagrees with term count");

endmodule

bind shifted_parity_correlation_sums_core spcs_checker u_spcs_checker (.*);

/* verif/spcs_sums_checker.sv */
`timescale 1ns / 1ps
// Result checker for shifted_parity_correlation_sums_core: tracks parity and shift
// writes, predicts each report beat and compares it field by field. Needs spcs_pkg.
module spcs_sums_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_parity_bit,
   input  logic                   req_report,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  spcs_pkg::sum_out_type  rsp_sum_four,
   input  spcs_pkg::sum_out_type  rsp_sum_first_pair,
   input  spcs_pkg::sum_out_type  rsp_sum_second_pair,
   input  spcs_pkg::count_type    rsp_terms_done,
   input  logic                   rsp_overflowed,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  spcs_pkg::csr_idx_type  csr_index,
   input  spcs_pkg::csr_data_type csr_wdata,
   output int                     fail_count,
   output int                     reports_pending
);
   import spcs_pkg::*;

   typedef struct {
      sum_out_type four;
      sum_out_type first;
      sum_out_type second;
      count_type   terms;
      logic        ovf;
   } sums_report_type;

   sums_report_type        expected_reports[$];
   sums_report_type        oldest_report;
   logic [WINDOW_BITS-1:0] parity_hist;      // bit 0 is the newest parity bit
   int unsigned            bits_seen;
   acc_type                acc_four;
   acc_type                acc_first;
   acc_type                acc_second;
   count_type              term_count;
   logic                   sat_seen;
   shift_k_type            shift_k;
   shift_h_type            shift_h;
   int                     errors = 0;

   task automatic bump_sum(inout acc_type acc, input logic down);
      if (down) begin
         if (acc <= SUM_MIN) sat_seen = 1'b1;
         else acc = acc - acc_type'(1);
      end else begin
         if (acc >= SUM_MAX) sat_seen = 1'b1;
         else acc = acc + acc_type'(1);
      end
   endtask

   task automatic fold_parity_beat(input logic pbit, input logic want_report);
      int unsigned     span;
      logic            a;
      logic            b;
      sums_report_type rpt;
      span = int'(shift_k) + int'(shift_h);
      parity_hist = {parity_hist[WINDOW_BITS-2:0], pbit};
      if (bits_seen < WINDOW_BITS) bits_seen++;
      // the newest bit completes the term for n = newest - (k + h)
      if (span < WINDOW_BITS && bits_seen > span) begin
         a = parity_hist[span] ^ parity_hist[shift_h];
         b = parity_hist[shift_k] ^ parity_hist[0];
         bump_sum(acc_four, a ^ b);
         bump_sum(acc_first, a);
         bump_sum(acc_second, b);
         if (term_count == COUNT_MAX) sat_seen = 1'b1;
         else term_count++;
      end
      if (want_report) begin
         rpt.four   = acc_four;
         rpt.first  = acc_first;
         rpt.second = acc_second;
         rpt.terms  = term_count;
         rpt.ovf    = sat_seen;
         expected_reports.push_back(rpt);
      end
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_reports.delete();
         parity_hist = '0;
         bits_seen   = 0;
         acc_four    = '0;
         acc_first   = '0;
         acc_second  = '0;
         term_count  = '0;
         sat_seen    = 1'b0;
         shift_k     = RESET_SHIFT_K;
         shift_h     = RESET_SHIFT_H;
      end else begin
         // a result beat is always for an earlier request beat, so pop first
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               $error("result beat with no report pending");
               errors++;
            end else begin
               oldest_report = expected_reports.pop_front();
               compare_field("sum_four", oldest_report.four, rsp_sum_four);
               compare_field("sum_first_pair", oldest_report.first, rsp_sum_first_pair);
               compare_field("sum_second_pair", oldest_report.second, rsp_sum_second_pair);
               compare_field("terms_done", oldest_report.terms, rsp_terms_done);
               compare_field("overflowed", oldest_report.ovf, rsp_overflowed);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SHIFT_K: shift_k = csr_wdata[SHIFT_K_WIDTH-1:0];
               REG_SHIFT_H: shift_h = csr_wdata[SHIFT_H_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) fold_parity_beat(req_parity_bit, req_report);
      end
      fail_count      <= errors;
      reports_pending <= expected_reports.size();
   end

endmodule

/* verif/tb_shifted_parity_correlation_sums_core.sv */
`timescale 1ns / 1ps
// Testbench top for shifted_parity_correlation_sums_core: drives parity beats and
// shift writes with bursty traffic, and gives the verdict. Needs spcs_pkg and spcs_sums_checker.
module tb_shifted_parity_correlation_sums_core;
   import spcs_pkg::*;

   localparam int RANDOM_BEATS = 550;
   localparam int SETTLE_CYCLES = 4;     // pipeline depth with margin
   localparam int END_CYCLES = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_parity_bit = 1'b0;
   logic         req_report = 1'b0;
   logic         rsp_ready = 1'b0;
   logic         csr_valid = 1'b0;
   csr_idx_type  csr_index = '0;
   csr_data_type csr_wdata = '0;

   logic         req_ready;
   logic         rsp_valid;
   sum_out_type  rsp_sum_four;
   sum_out_type  rsp_sum_first_pair;
   sum_out_type  rsp_sum_second_pair;
   count_type    rsp_terms_done;
   logic         rsp_overflowed;
   logic         csr_ready;

   logic         req_fire = 1'b0;
   logic         csr_fire = 1'b0;
   int           fail_count;
   int           reports_pending;
   int           burst_left = 0;
   int           stall_left = 0;
   int           stall_mode = 0;

   always #1 clock = ~clock;

   // handshakes seen at the rising edge, read back at the following falling edge
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      csr_fire <= csr_valid && csr_ready;
   end

   // receiver: stretches of always-ready, random and mostly-stalled
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(4, 40);
      end
      stall_left--;
      case (stall_mode)
         2:       rsp_ready = 1'($urandom_range(0, 1));
         3:       rsp_ready = ($urandom_range(0, 3) == 0);
         default: rsp_ready = 1'b1;
      endcase
   end

   shifted_parity_correlation_sums_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_parity_bit     (req_parity_bit),
      .req_report         (req_report),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sum_four       (rsp_sum_four),
      .rsp_sum_first_pair (rsp_sum_first_pair),
      .rsp_sum_second_pair(rsp_sum_second_pair),
      .rsp_terms_done     (rsp_terms_done),
      .rsp_overflowed     (rsp_overflowed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   spcs_sums_checker sums_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_parity_bit     (req_parity_bit),
      .req_report         (req_report),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sum_four       (rsp_sum_four),
      .rsp_sum_first_pair (rsp_sum_first_pair),
      .rsp_sum_second_pair(rsp_sum_second_pair),
      .rsp_terms_done     (rsp_terms_done),
      .rsp_overflowed     (rsp_overflowed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .reports_pending    (reports_pending)
   );

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_parity(input logic pbit, input logic want_report);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid = 1'b0;
            req_parity_bit = 1'($urandom_range(0, 1));
            req_report = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_parity_bit = pbit;
      req_report = want_report;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic write_shift(input csr_idx_type idx, input csr_data_type data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(negedge clock); while (!csr_fire);
      csr_valid = 1'b0;
   endtask

   // idle the request side until every report is back and the pipeline is empty
   task automatic drain_sums();
      req_valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int           sent;
      int           beats;
      int           pattern;
      int           kv;
      int           hv;
      logic         pbit;
      csr_data_type data;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // default shifts (span 17): reports before and right at the first term
      for (int i = 0; i < 20; i++)
         send_parity((i < 4) ? 1'b1 : logic'(i[0] ^ i[2]), (i < 3) || (i >= 17));
      drain_sums();

      // span of 64 is too wide: sums and count hold; high data bits are dropped
      write_shift(REG_SHIFT_K, 8'hFF);
      write_shift(REG_SHIFT_H, 8'hE1);
      write_shift(csr_idx_type'(15), 8'h00);
      send_parity(1'b1, 1'b0);
      send_parity(1'b0, 1'b1);
      drain_sums();

      // both shifts zero
      write_shift(REG_SHIFT_K, 8'h00);
      write_shift(REG_SHIFT_H, 8'hC0);
      for (int i = 0; i < 3; i++) send_parity(logic'(i[0]), 1'b1);

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         drain_sums();
         case ($urandom_range(0, 4))
            0:       kv = 1;
            1:       kv = 31;
            2:       kv = 0;
            default: kv = $urandom_range(0, 31);
         endcase
         case ($urandom_range(0, 5))
            0:       hv = 1;
            1:       hv = 32;
            2:       hv = $urandom_range(33, 63);
            default: hv = $urandom_range(0, 32);
         endcase
         data = csr_data_type'($urandom_range(0, 255));
         data[SHIFT_K_WIDTH-1:0] = SHIFT_K_WIDTH'(kv);
         write_shift(REG_SHIFT_K, data);
         data = csr_data_type'($urandom_range(0, 255));
         data[SHIFT_H_WIDTH-1:0] = SHIFT_H_WIDTH'(hv);
         write_shift(REG_SHIFT_H, data);
         if ($urandom_range(0, 3) == 0)
            write_shift(csr_idx_type'($urandom_range(2, 15)),
                        csr_data_type'($urandom_range(0, 255)));

         pattern = $urandom_range(0, 3);
         beats = $urandom_range(20, 70);
         for (int i = 0; i < beats; i++) begin
            case (pattern)
               1:       pbit = ($urandom_range(0, 7) != 0);
               2:       pbit = ($urandom_range(0, 7) == 0);
               default: pbit = 1'($urandom_range(0, 1));
            endcase
            send_parity(pbit, $urandom_range(0, 5) == 0);
         end
         sent += beats;
      end

      drain_sums();
      repeat (END_CYCLES) @(negedge clock);
      if (fail_count == 0 && reports_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
